// File: src/yc2bgra_pkg.sv
// shared types, format codes and fixed-point constants for the ycbcr 4:2:2 to bgra converter
// used by yc2bgra_pixel and packed_ycbcr422_to_bgra_top; depends on nothing
package yc2bgra_pkg;

	// source format codes held in the format register
	localparam logic [1:0] FMT_YUY2  = 2'd0;
	localparam logic [1:0] FMT_UYVY  = 2'd1;
	localparam logic [1:0] FMT_RGB24 = 2'd2;
	localparam logic [1:0] FMT_RGB32 = 2'd3;

	// bt.601 coefficients scaled by 1000
	localparam int COEF_CB_B = 1772;
	localparam int COEF_CB_G = 344;
	localparam int COEF_CR_G = 714;
	localparam int COEF_CR_R = 1402;
	localparam int COEF_SCALE = 1000;

	// reciprocal shift for exact truncating division of the products by 1000
	localparam int RECIP_SHIFT = 20;
	localparam int RECIP_W = 21;

	// width of a signed component sum before clamping
	localparam int SUM_W = 11;

	localparam logic [7:0] CHROMA_ZERO = 8'd128;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// one input beat: four packed source bytes
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
		logic [7:0] byte3;
	} in_beat_t;

	// one output beat: a bgra pixel and the end marker for its input item
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic       last_of_run;
	} out_beat_t;

	// saturate a signed sum to 0..255
	function automatic logic [7:0] clamp_u8(input logic signed [SUM_W-1:0] v);
		logic [7:0] res;
		if (v < 0) begin
			res = 8'd0;
		end else if (v > $signed(SUM_W'(255))) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

// File: src/packed_ycbcr422_to_bgra_top.sv
// input stage: holds an accepted beat until its last pixel is loaded into the output register
// pixels per item: yuy2/uyvy items give two pixels through the one pixel datapath,
// rgb24/rgb32 items give one; the output register reloads in the cycle its pixel is taken
// reset: arst_n clears the format register to yuy2 and empties the input and output stages
// holds the input stage, format register, pixel select and output register
// depends on yc2bgra_pkg and yc2bgra_pixel
module packed_ycbcr422_to_bgra_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  yc2bgra_pkg::in_beat_t  in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output yc2bgra_pkg::out_beat_t out_data
);

	logic [1:0]             fmt_q;
	logic                   v_s1;
	logic [1:0]             fmt_s1;
	yc2bgra_pkg::in_beat_t  beat_s1;
	logic                   phase_q;
	logic                   out_v_q;
	yc2bgra_pkg::out_beat_t out_q;

	logic                   in_take, out_load, last_pix, consume;
	logic [7:0]             y0, y1, cb, cr, y_sel;
	logic [7:0]             pix_b, pix_g, pix_r;
	yc2bgra_pkg::out_beat_t res;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= yc2bgra_pkg::FMT_YUY2;
		end else if (cfg_we) begin
			fmt_q <= cfg_data;
		end
	end

	// handshake control
	assign last_pix = fmt_s1[1] | phase_q;
	assign out_load = v_s1 & (~out_v_q | ~out_stall);
	assign consume  = out_load & last_pix;
	assign in_stall = v_s1 & ~consume;
	assign in_take  = in_valid & ~in_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_take) begin
			v_s1 <= 1'b1;
		end else if (consume) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			beat_s1 <= in_data;
			fmt_s1  <= fmt_q;
		end
	end

	// pixel select within a 4:2:2 item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (out_load) begin
			phase_q <= ~last_pix;
		end
	end

	// unpack luma and chroma by byte order
	always_comb begin
		case (fmt_s1)
			yc2bgra_pkg::FMT_UYVY: begin
				cb = beat_s1.byte0;
				y0 = beat_s1.byte1;
				cr = beat_s1.byte2;
				y1 = beat_s1.byte3;
			end
			default: begin
				y0 = beat_s1.byte0;
				cb = beat_s1.byte1;
				y1 = beat_s1.byte2;
				cr = beat_s1.byte3;
			end
		endcase
	end

	assign y_sel = phase_q ? y1 : y0;

	yc2bgra_pixel u_pixel (
		.y     (y_sel),
		.cb    (cb),
		.cr    (cr),
		.blue  (pix_b),
		.green (pix_g),
		.red   (pix_r)
	);

	// result beat by format
	always_comb begin
		res.last_of_run = last_pix;
		case (fmt_s1)
			yc2bgra_pkg::FMT_RGB24: begin
				res.blue  = beat_s1.byte2;
				res.green = beat_s1.byte1;
				res.red   = beat_s1.byte0;
				res.alpha = yc2bgra_pkg::ALPHA_OPAQUE;
			end
			yc2bgra_pkg::FMT_RGB32: begin
				res.blue  = beat_s1.byte0;
				res.green = beat_s1.byte1;
				res.red   = beat_s1.byte2;
				res.alpha = beat_s1.byte3;
			end
			default: begin
				res.blue  = pix_b;
				res.green = pix_g;
				res.red   = pix_r;
				res.alpha = yc2bgra_pkg::ALPHA_OPAQUE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (~out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

// File: src/yc2bgra_pixel.sv
// ycbcr to rgb arithmetic for one pixel: chroma terms by constant reciprocal multiply
// depends on yc2bgra_pkg
module yc2bgra_pixel (
	input  logic [7:0] y,
	input  logic [7:0] cb,
	input  logic [7:0] cr,
	output logic [7:0] blue,
	output logic [7:0] green,
	output logic [7:0] red
);

	localparam int SH = yc2bgra_pkg::RECIP_SHIFT;
	localparam int RW = yc2bgra_pkg::RECIP_W;
	localparam int SW = yc2bgra_pkg::SUM_W;
	localparam int PW = 8 + RW;
	localparam int QW = PW - SH;

	// ceil(coef * 2^SH / 1000): exact floor division for magnitudes up to 128
	localparam logic [RW-1:0] K_CB_B = RW'((yc2bgra_pkg::COEF_CB_B * (2 ** SH)
		+ yc2bgra_pkg::COEF_SCALE - 1) / yc2bgra_pkg::COEF_SCALE);
	localparam logic [RW-1:0] K_CB_G = RW'((yc2bgra_pkg::COEF_CB_G * (2 ** SH)
		+ yc2bgra_pkg::COEF_SCALE - 1) / yc2bgra_pkg::COEF_SCALE);
	localparam logic [RW-1:0] K_CR_G = RW'((yc2bgra_pkg::COEF_CR_G * (2 ** SH)
		+ yc2bgra_pkg::COEF_SCALE - 1) / yc2bgra_pkg::COEF_SCALE);
	localparam logic [RW-1:0] K_CR_R = RW'((yc2bgra_pkg::COEF_CR_R * (2 ** SH)
		+ yc2bgra_pkg::COEF_SCALE - 1) / yc2bgra_pkg::COEF_SCALE);

	logic          cb_neg, cr_neg;
	logic [7:0]    cb_mag, cr_mag;
	logic [PW-1:0] p_cb_b, p_cb_g, p_cr_g, p_cr_r;
	logic [QW-1:0] q_cb_b, q_cb_g, q_cr_g, q_cr_r;
	logic signed [SW-1:0] t_cb_b, t_cb_g, t_cr_g, t_cr_r;
	logic signed [SW-1:0] y_s, sum_b, sum_g, sum_r;

	// sign and magnitude of the offset chroma values
	assign cb_neg = ~cb[7];
	assign cr_neg = ~cr[7];
	assign cb_mag = cb[7] ? {1'b0, cb[6:0]} : (yc2bgra_pkg::CHROMA_ZERO - cb);
	assign cr_mag = cr[7] ? {1'b0, cr[6:0]} : (yc2bgra_pkg::CHROMA_ZERO - cr);

	// magnitude times scaled reciprocal, top bits give the truncated quotient
	assign p_cb_b = PW'(cb_mag) * PW'(K_CB_B);
	assign p_cb_g = PW'(cb_mag) * PW'(K_CB_G);
	assign p_cr_g = PW'(cr_mag) * PW'(K_CR_G);
	assign p_cr_r = PW'(cr_mag) * PW'(K_CR_R);
	assign q_cb_b = p_cb_b[PW-1:SH];
	assign q_cb_g = p_cb_g[PW-1:SH];
	assign q_cr_g = p_cr_g[PW-1:SH];
	assign q_cr_r = p_cr_r[PW-1:SH];

	// restore sign, truncation toward zero
	assign t_cb_b = cb_neg ? -$signed(SW'(q_cb_b)) : $signed(SW'(q_cb_b));
	assign t_cb_g = cb_neg ? -$signed(SW'(q_cb_g)) : $signed(SW'(q_cb_g));
	assign t_cr_g = cr_neg ? -$signed(SW'(q_cr_g)) : $signed(SW'(q_cr_g));
	assign t_cr_r = cr_neg ? -$signed(SW'(q_cr_r)) : $signed(SW'(q_cr_r));

	// component sums and saturation
	assign y_s   = $signed(SW'(y));
	assign sum_b = y_s + t_cb_b;
	assign sum_g = y_s - t_cb_g - t_cr_g;
	assign sum_r = y_s + t_cr_r;

	assign blue  = yc2bgra_pkg::clamp_u8(sum_b);
	assign green = yc2bgra_pkg::clamp_u8(sum_g);
	assign red   = yc2bgra_pkg::clamp_u8(sum_r);

endmodule
